@@ rtl/core/qylp_pkg.sv @@
// Package with the transaction types and constants of the link pose yaw block.
package qylp_pkg;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               apply_offset;
  } pose_req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [15:0] yaw;
  } pose_res_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               apply_offset;
  } side_t;

  localparam int unsigned AtanTabLen = 24;
  localparam int unsigned VecW       = 38;
  localparam int unsigned RotW       = 36;
  localparam int unsigned AngW       = 34;

  localparam logic [15:0] LinkOffsetReset = 16'd3555;
  localparam logic [29:0] InvGainQ30      = 30'd652032874;

  localparam logic signed [AngW-1:0] PiAng     = 34'sd2147483648;
  localparam logic signed [AngW-1:0] HalfPiAng = 34'sd1073741824;

  localparam logic [29:0] AtanTab [AtanTabLen] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
  };

endpackage

@@ rtl/core/quaternion_yaw_link_pose.sv @@
// Top level: quaternion to yaw with CORDIC pipelines and a forward position offset.
//
// Usage: a transaction enters on req_i when start_i is high and busy_o is low.
// busy_o is always low, so a new pose may be offered in every clock cycle.
// Each result appears on result_o for exactly one cycle with done_o high.
// Results leave in request order, one per request.
// The work is a fully unrolled pipeline: a product stage, a quadrant stage and
// one register stage per vectoring CORDIC iteration, a rounding stage, a
// pre-rotation stage, one stage per rotation CORDIC iteration and a final
// saturating add.
// Throughput is one transaction per cycle, set by that pipeline.
// The receiver cannot stall; done_o is a strobe and the data is gone after it.
// Reset clears all valid bits, so nothing in flight survives it, and sets the
// link offset register to 3555.
// cfg_we_i with cfg_wdata_i writes the link offset; write it only when idle.
module quaternion_yaw_link_pose
  import qylp_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  pose_req_t   req_i,
  output logic        done_o,
  output pose_res_t   result_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned NStg = (CORDIC_STAGES > AtanTabLen) ? AtanTabLen : CORDIC_STAGES;
  localparam int unsigned Lat  = 2 * NStg + 5;

  logic [15:0] link_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_offset_q <= LinkOffsetReset;
    end else if (cfg_we_i) begin
      link_offset_q <= cfg_wdata_i;
    end
  end

  assign busy_o = 1'b0;

  logic                s0_vld_q;
  logic signed [31:0]  p_xy_q, p_wz_q, p_yy_q, p_zz_q;
  side_t               s0_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    p_xy_q    <= 32'(req_i.quat_x * req_i.quat_y);
    p_wz_q    <= 32'(req_i.quat_w * req_i.quat_z);
    p_yy_q    <= 32'(req_i.quat_y * req_i.quat_y);
    p_zz_q    <= 32'(req_i.quat_z * req_i.quat_z);
    s0_side_q <= '{pos_x: req_i.pos_x, pos_y: req_i.pos_y, apply_offset: req_i.apply_offset};
  end

  logic [NStg:0]             v_vld_q;
  logic signed [VecW-1:0]    v_x_q [NStg+1];
  logic signed [VecW-1:0]    v_y_q [NStg+1];
  logic signed [AngW-1:0]    v_a_q [NStg+1];
  logic [NStg:0]             v_zero_q;
  side_t                     v_side_q [NStg+1];

  logic signed [VecW-1:0]    num_d, den_d;

  always_comb begin
    num_d = VecW'(2) * (VecW'(p_xy_q) + VecW'(p_wz_q));
    den_d = (VecW'(1) <<< 30) - VecW'(2) * (VecW'(p_yy_q) + VecW'(p_zz_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_vld_q <= '0;
    end else begin
      v_vld_q <= {v_vld_q[NStg-1:0], s0_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    v_zero_q[0] <= (num_d == '0) && (den_d == '0);
    v_side_q[0] <= s0_side_q;
    if (den_d < 0) begin
      v_x_q[0] <= -den_d;
      v_y_q[0] <= -num_d;
      v_a_q[0] <= (num_d >= 0) ? PiAng : -PiAng;
    end else begin
      v_x_q[0] <= den_d;
      v_y_q[0] <= num_d;
      v_a_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < NStg; i++) begin : g_vec
    always_ff @(posedge clk_i) begin
      v_zero_q[i+1] <= v_zero_q[i];
      v_side_q[i+1] <= v_side_q[i];
      if (v_y_q[i] >= 0) begin
        v_x_q[i+1] <= v_x_q[i] + (v_y_q[i] >>> i);
        v_y_q[i+1] <= v_y_q[i] - (v_x_q[i] >>> i);
        v_a_q[i+1] <= v_a_q[i] + AngW'(AtanTab[i]);
      end else begin
        v_x_q[i+1] <= v_x_q[i] - (v_y_q[i] >>> i);
        v_y_q[i+1] <= v_y_q[i] + (v_x_q[i] >>> i);
        v_a_q[i+1] <= v_a_q[i] - AngW'(AtanTab[i]);
      end
    end
  end

  logic                   y_vld_q;
  logic signed [15:0]     y_yaw_q;
  logic [31:0]            y_mag_q;
  side_t                  y_side_q;
  logic [AngW-1:0]        ang_rnd_d;
  logic [45:0]            mag_prod_d;

  always_comb begin
    ang_rnd_d  = (v_zero_q[NStg] ? '0 : v_a_q[NStg]) + AngW'(32768);
    mag_prod_d = 46'(link_offset_q) * 46'(InvGainQ30);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_vld_q <= 1'b0;
    end else begin
      y_vld_q <= v_vld_q[NStg];
    end
  end

  always_ff @(posedge clk_i) begin
    y_yaw_q  <= ang_rnd_d[31:16];
    y_mag_q  <= mag_prod_d[45:14];
    y_side_q <= v_side_q[NStg];
  end

  logic [NStg:0]             r_vld_q;
  logic signed [RotW-1:0]    r_x_q [NStg+1];
  logic signed [RotW-1:0]    r_y_q [NStg+1];
  logic signed [AngW-1:0]    r_z_q [NStg+1];
  logic signed [15:0]        r_yaw_q [NStg+1];
  side_t                     r_side_q [NStg+1];
  logic signed [AngW-1:0]    z_d;
  logic signed [RotW-1:0]    mag_d;

  always_comb begin
    z_d   = AngW'(y_yaw_q) <<< 16;
    mag_d = RotW'({1'b0, y_mag_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= '0;
    end else begin
      r_vld_q <= {r_vld_q[NStg-1:0], y_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    r_y_q[0]    <= '0;
    r_yaw_q[0]  <= y_yaw_q;
    r_side_q[0] <= y_side_q;
    if (z_d > HalfPiAng) begin
      r_x_q[0] <= -mag_d;
      r_z_q[0] <= z_d - PiAng;
    end else if (z_d < -HalfPiAng) begin
      r_x_q[0] <= -mag_d;
      r_z_q[0] <= z_d + PiAng;
    end else begin
      r_x_q[0] <= mag_d;
      r_z_q[0] <= z_d;
    end
  end

  for (genvar i = 0; i < NStg; i++) begin : g_rot
    always_ff @(posedge clk_i) begin
      r_yaw_q[i+1]  <= r_yaw_q[i];
      r_side_q[i+1] <= r_side_q[i];
      if (r_z_q[i] >= 0) begin
        r_x_q[i+1] <= r_x_q[i] - (r_y_q[i] >>> i);
        r_y_q[i+1] <= r_y_q[i] + (r_x_q[i] >>> i);
        r_z_q[i+1] <= r_z_q[i] - AngW'(AtanTab[i]);
      end else begin
        r_x_q[i+1] <= r_x_q[i] + (r_y_q[i] >>> i);
        r_y_q[i+1] <= r_y_q[i] - (r_x_q[i] >>> i);
        r_z_q[i+1] <= r_z_q[i] + AngW'(AtanTab[i]);
      end
    end
  end

  logic                   done_q;
  pose_res_t              res_q;
  logic signed [RotW:0]   dx_rnd_d, dy_rnd_d;
  logic signed [33:0]     sum_x_d, sum_y_d;
  logic signed [31:0]     sat_x_d, sat_y_d;
  side_t                  f_side_d;

  always_comb begin
    f_side_d = r_side_q[NStg];
    dx_rnd_d = (RotW+1)'(r_x_q[NStg]) + (RotW+1)'(32768);
    dy_rnd_d = (RotW+1)'(r_y_q[NStg]) + (RotW+1)'(32768);
    sum_x_d  = 34'(f_side_d.pos_x) + 34'(dx_rnd_d >>> 16);
    sum_y_d  = 34'(f_side_d.pos_y) + 34'(dy_rnd_d >>> 16);
    if (sum_x_d > 34'sd2147483647) begin
      sat_x_d = 32'sh7FFFFFFF;
    end else if (sum_x_d < -34'sd2147483648) begin
      sat_x_d = 32'sh80000000;
    end else begin
      sat_x_d = sum_x_d[31:0];
    end
    if (sum_y_d > 34'sd2147483647) begin
      sat_y_d = 32'sh7FFFFFFF;
    end else if (sum_y_d < -34'sd2147483648) begin
      sat_y_d = 32'sh80000000;
    end else begin
      sat_y_d = sum_y_d[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= r_vld_q[NStg];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.yaw   <= r_yaw_q[NStg];
    res_q.out_x <= f_side_d.apply_offset ? sat_x_d : f_side_d.pos_x;
    res_q.out_y <= f_side_d.apply_offset ? sat_y_d : f_side_d.pos_y;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(Lat) done_o)
    else $error("accepted transaction did not complete on time");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(r_vld_q[NStg]))
    else $error("result strobe without a transaction in flight");

  a_passthrough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_vld_q[NStg] && !f_side_d.apply_offset) |=>
      (result_o.out_x == $past(f_side_d.pos_x) && result_o.out_y == $past(f_side_d.pos_y)))
    else $error("position changed without offset request");
`endif

endmodule
